/* design/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/bqlp_pkg.sv */
// Package: constants, types and microcode ROM of the biquad low-pass unit.
package bqlp_pkg;

  localparam int CHANNELS   = 9;
  localparam int STATE_BITS = 40;

  localparam int CHAN_W   = 4;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int SPLIT    = 24;
  localparam int W_FRAC   = 16;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // s = w0 + 2*w1 + w2
  localparam int SUM_W  = STATE_BITS + 3;
  localparam int MB_W   = (SUM_W - SPLIT > SPLIT + 1) ? SUM_W - SPLIT : SPLIT + 1;
  localparam int PROD_W = COEF_W + MB_W;
  localparam int ACC_W  = STATE_BITS + 27;
  localparam int W0_SH  = 22;
  localparam int W0F_W  = ACC_W - W0_SH;
  localparam int Y_SH   = 38;
  localparam int Y_W    = ACC_W - Y_SH;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_ENTRY = 4'd0;
  localparam logic [PC_W-1:0] PC_FIN   = 4'd10;

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_B0     = 2'd1,
    REG_A1     = 2'd2,
    REG_A2     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CA_A1,
    CA_A2,
    CA_B0
  } coef_sel_t;

  typedef enum logic [2:0] {
    OB_W1LO,
    OB_W1HI,
    OB_W2LO,
    OB_W2HI,
    OB_SLO,
    OB_SHI
  } opnd_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_INIT_X,
    ACC_INIT_RND,
    ACC_SUB,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_BYPASS,
    JC_OUT_BUSY
  } jcond_t;

  typedef struct packed {
    coef_sel_t       mul_a;
    opnd_sel_t       mul_b;
    acc_op_t         acc_op;
    logic            acc_hi;
    logic            ld_w0;
    logic            ld_s;
    jcond_t          cond;
    logic [PC_W-1:0] target;
    logic            last;
  } ucode_t;

  typedef struct packed {
    logic bypass;
    logic out_busy;
  } seq_status_t;

  typedef struct packed {
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
    logic                       guard_hit;
  } result_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uc;
    uc = '0;
    uc.mul_a  = CA_A1;
    uc.mul_b  = OB_W1LO;
    uc.acc_op = ACC_HOLD;
    uc.cond   = JC_NONE;
    case (pc)
      4'd0: begin
        uc.acc_op = ACC_INIT_X;
        uc.cond   = JC_BYPASS;
        uc.target = PC_FIN;
      end
      4'd1: begin
        uc.mul_b  = OB_W1HI;
        uc.acc_op = ACC_SUB;
      end
      4'd2: begin
        uc.mul_a  = CA_A2;
        uc.mul_b  = OB_W2LO;
        uc.acc_op = ACC_SUB;
        uc.acc_hi = 1'b1;
      end
      4'd3: begin
        uc.mul_a  = CA_A2;
        uc.mul_b  = OB_W2HI;
        uc.acc_op = ACC_SUB;
      end
      4'd4: begin
        uc.acc_op = ACC_SUB;
        uc.acc_hi = 1'b1;
      end
      4'd5: begin
        uc.ld_w0 = 1'b1;
      end
      4'd6: begin
        uc.ld_s   = 1'b1;
        uc.acc_op = ACC_INIT_RND;
      end
      4'd7: begin
        uc.mul_a = CA_B0;
        uc.mul_b = OB_SLO;
      end
      4'd8: begin
        uc.mul_a  = CA_B0;
        uc.mul_b  = OB_SHI;
        uc.acc_op = ACC_ADD;
      end
      4'd9: begin
        uc.acc_op = ACC_ADD;
        uc.acc_hi = 1'b1;
      end
      PC_FIN: begin
        uc.cond   = JC_OUT_BUSY;
        uc.target = PC_FIN;
        uc.last   = 1'b1;
      end
      default: begin
        uc.last = 1'b1;
      end
    endcase
    return uc;
  endfunction

endpackage

/* design/bqlp_seq.sv */
// Microcode sequencer: step counter, control ROM and conditional jumps.
`include "assert_macros.svh"

module bqlp_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  bqlp_pkg::seq_status_t status,
  output bqlp_pkg::ucode_t     ctl,
  output logic                 busy,
  output logic                 emit
);

  logic                        busy_r, busy_nxt;
  logic [bqlp_pkg::PC_W-1:0]   pc_r, pc_nxt;
  bqlp_pkg::ucode_t            uc;
  logic                        take_jump;

  always_comb begin
    uc = bqlp_pkg::ucode_rom(pc_r);
    case (uc.cond)
      bqlp_pkg::JC_BYPASS:   take_jump = status.bypass;
      bqlp_pkg::JC_OUT_BUSY: take_jump = status.out_busy;
      default:               take_jump = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = bqlp_pkg::PC_ENTRY;
      end
    end else if (take_jump) begin
      pc_nxt = uc.target;
    end else if (uc.last) begin
      busy_nxt = 1'b0;
      pc_nxt   = bqlp_pkg::PC_ENTRY;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  // control outputs
  always_comb begin
    ctl  = busy_r ? uc : '0;
    busy = busy_r;
    emit = busy_r && uc.last && !take_jump;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= bqlp_pkg::PC_ENTRY;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  `ASSERT_NEXT(a_emit_ends, clk, rst_n, emit, !busy_r)
  `ASSERT_NOW(a_idle_pc, clk, rst_n, !busy_r, pc_r == bqlp_pkg::PC_ENTRY)

endmodule

/* design/bqlp_dp.sv */
// Datapath: history file, shared multiplier, accumulator and result shaping.
`include "assert_macros.svh"

module bqlp_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [bqlp_pkg::CHAN_W-1:0]          in_channel,
  input  logic signed [bqlp_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 enable,
  input  logic signed [bqlp_pkg::COEF_W-1:0]   coef_b0,
  input  logic signed [bqlp_pkg::COEF_W-1:0]   coef_a1,
  input  logic signed [bqlp_pkg::COEF_W-1:0]   coef_a2,
  input  bqlp_pkg::ucode_t                     ctl,
  input  logic                                 emit,
  output logic                                 bypass,
  output bqlp_pkg::result_t                    res
);

  localparam int SB = bqlp_pkg::STATE_BITS;
  localparam int SP = bqlp_pkg::SPLIT;

  logic [SB-1:0] hist1_r [bqlp_pkg::CHANNELS];
  logic [SB-1:0] hist2_r [bqlp_pkg::CHANNELS];

  logic [bqlp_pkg::CHAN_W-1:0]          ch_r;
  logic [bqlp_pkg::IDX_W-1:0]           idx_r, idx_nxt;
  logic signed [bqlp_pkg::SAMPLE_W-1:0] x_r;
  logic                                 bypass_r, bypass_nxt;
  logic signed [SB-1:0]                 w1_r, w2_r, w0_r, w0_nxt;
  logic                                 guard_r;
  logic signed [bqlp_pkg::SUM_W-1:0]    s_r;
  logic signed [bqlp_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [bqlp_pkg::ACC_W-1:0]    acc_r, acc_nxt, addend;
  logic signed [bqlp_pkg::COEF_W-1:0]   ma;
  logic signed [bqlp_pkg::MB_W-1:0]     mb;
  logic signed [bqlp_pkg::W0F_W-1:0]    w0_full;
  logic                                 ovf;
  logic signed [SB-1:0]                 x_state;
  logic signed [bqlp_pkg::Y_W-1:0]      y_full;
  logic signed [bqlp_pkg::SAMPLE_W-1:0] y_sat;
  logic                                 clip;

  localparam logic signed [bqlp_pkg::Y_W-1:0] YMAX = bqlp_pkg::Y_W'(32767);
  localparam logic signed [bqlp_pkg::Y_W-1:0] YMIN = -bqlp_pkg::Y_W'(32768);

  always_comb begin
    bypass_nxt = !enable || (32'(in_channel) >= bqlp_pkg::CHANNELS);
    idx_nxt    = bypass_nxt ? '0 : in_channel[bqlp_pkg::IDX_W-1:0];
  end

  // operand select for the shared multiplier
  always_comb begin
    case (ctl.mul_a)
      bqlp_pkg::CA_A2: ma = coef_a2;
      bqlp_pkg::CA_B0: ma = coef_b0;
      default:         ma = coef_a1;
    endcase
    case (ctl.mul_b)
      bqlp_pkg::OB_W1HI: mb = bqlp_pkg::MB_W'($signed(w1_r[SB-1:SP]));
      bqlp_pkg::OB_W2LO: mb = bqlp_pkg::MB_W'({1'b0, w2_r[SP-1:0]});
      bqlp_pkg::OB_W2HI: mb = bqlp_pkg::MB_W'($signed(w2_r[SB-1:SP]));
      bqlp_pkg::OB_SLO:  mb = bqlp_pkg::MB_W'({1'b0, s_r[SP-1:0]});
      bqlp_pkg::OB_SHI:  mb = bqlp_pkg::MB_W'($signed(s_r[bqlp_pkg::SUM_W-1:SP]));
      default:           mb = bqlp_pkg::MB_W'({1'b0, w1_r[SP-1:0]});
    endcase
    prod_nxt = bqlp_pkg::PROD_W'(ma) * bqlp_pkg::PROD_W'(mb);
  end

  always_comb begin
    addend = ctl.acc_hi ? (bqlp_pkg::ACC_W'(prod_r) <<< SP) : bqlp_pkg::ACC_W'(prod_r);
    case (ctl.acc_op)
      bqlp_pkg::ACC_INIT_X:
        acc_nxt = (bqlp_pkg::ACC_W'(x_r) <<< bqlp_pkg::Y_SH) +
                  (bqlp_pkg::ACC_W'(1) <<< (bqlp_pkg::W0_SH - 1));
      bqlp_pkg::ACC_INIT_RND: acc_nxt = bqlp_pkg::ACC_W'(1) <<< (bqlp_pkg::Y_SH - 1);
      bqlp_pkg::ACC_SUB:      acc_nxt = acc_r - addend;
      bqlp_pkg::ACC_ADD:      acc_nxt = acc_r + addend;
      default:                acc_nxt = acc_r;
    endcase
  end

  // w0 with state overflow guard
  always_comb begin
    w0_full = acc_r[bqlp_pkg::ACC_W-1:bqlp_pkg::W0_SH];
    ovf     = !((&w0_full[bqlp_pkg::W0F_W-1:SB-1]) || !(|w0_full[bqlp_pkg::W0F_W-1:SB-1]));
    x_state = SB'(x_r) <<< bqlp_pkg::W_FRAC;
    w0_nxt  = ovf ? x_state : w0_full[SB-1:0];
  end

  // rounded output with saturation
  always_comb begin
    y_full = acc_r[bqlp_pkg::ACC_W-1:bqlp_pkg::Y_SH];
    clip   = 1'b1;
    if (y_full > YMAX) begin
      y_sat = 16'sh7fff;
    end else if (y_full < YMIN) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y_full[bqlp_pkg::SAMPLE_W-1:0];
      clip  = 1'b0;
    end
    res.channel   = ch_r;
    res.filtered  = bypass_r ? x_r : y_sat;
    res.clipped   = !bypass_r && clip;
    res.guard_hit = !bypass_r && guard_r;
    bypass        = bypass_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b1;
    end else if (start) begin
      bypass_r <= bypass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ch_r  <= in_channel;
      x_r   <= in_sample;
      idx_r <= idx_nxt;
      w1_r  <= hist1_r[idx_nxt];
      w2_r  <= hist2_r[idx_nxt];
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (ctl.ld_w0) begin
      w0_r    <= w0_nxt;
      guard_r <= ovf;
    end
    if (ctl.ld_s) begin
      s_r <= bqlp_pkg::SUM_W'(w0_r) + (bqlp_pkg::SUM_W'(w1_r) <<< 1) + bqlp_pkg::SUM_W'(w2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bqlp_pkg::CHANNELS; i++) begin
        hist1_r[i] <= '0;
        hist2_r[i] <= '0;
      end
    end else if (emit && !bypass_r) begin
      hist2_r[idx_r] <= hist1_r[idx_r];
      hist1_r[idx_r] <= w0_r;
    end
  end

  `ASSERT_NEXT(a_guard_load, clk, rst_n, ctl.ld_w0 && ovf, guard_r && (w0_r == $past(x_state)))

endmodule

/* design/biquad_lowpass_multichannel_unit.sv */
// Top level: configuration registers, stream ports and output register.
//
// Second-order low-pass biquad (direct form II) shared by nine channels.
// Each input transaction carries a channel and a signed 16-bit sample; the
// channel selects its own pair of 40-bit delay words. Coefficients b0, a1,
// a2 are signed Q2.22 (b1 = 2*b0, b2 = b0) and written over the APB port;
// the user must write them only while the unit is idle; the unit does not
// enforce this. For a filtered sample, a 11-step microcode program drives
// one shared 24x25 multiplier through six products and the accumulator.
// With the filter disabled or a channel out of range the sample passes
// through and no history changes. The next input is taken in the cycle
// after a result is emitted. A finished result waits in the output
// register, so the next input can be taken while it is pending; a new
// result that finds it still full holds the sequencer until out_tready.
module biquad_lowpass_multichannel_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] channel, [19:4] sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] channel_out, [19:4] filtered
  output logic [1:0]  out_tuser,  // [0] clipped, [1] guard_hit
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                               enable_r;
  logic signed [bqlp_pkg::COEF_W-1:0] b0_r, a1_r, a2_r;
  bqlp_pkg::reg_idx_t                 cfg_idx;
  logic                               cfg_wr;

  logic                  start, busy, emit;
  bqlp_pkg::ucode_t      ctl;
  bqlp_pkg::seq_status_t status;
  bqlp_pkg::result_t     res, out_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  bypass;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = bqlp_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_idx)
      bqlp_pkg::REG_ENABLE: cfg_prdata = {31'd0, enable_r};
      bqlp_pkg::REG_B0:     cfg_prdata = {8'd0, b0_r};
      bqlp_pkg::REG_A1:     cfg_prdata = {8'd0, a1_r};
      bqlp_pkg::REG_A2:     cfg_prdata = {8'd0, a2_r};
      default:              cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      b0_r     <= '0;
      a1_r     <= '0;
      a2_r     <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bqlp_pkg::REG_ENABLE: enable_r <= cfg_pwdata[0];
        bqlp_pkg::REG_B0:     b0_r     <= cfg_pwdata[bqlp_pkg::COEF_W-1:0];
        bqlp_pkg::REG_A1:     a1_r     <= cfg_pwdata[bqlp_pkg::COEF_W-1:0];
        bqlp_pkg::REG_A2:     a2_r     <= cfg_pwdata[bqlp_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready       = !busy;
  assign start           = in_tvalid && in_tready;
  assign status.bypass   = bypass;
  assign status.out_busy = out_valid_r && !out_tready;

  bqlp_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .ctl    (ctl),
    .busy   (busy),
    .emit   (emit)
  );

  bqlp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_channel (in_tdata[3:0]),
    .in_sample  (in_tdata[19:4]),
    .enable     (enable_r),
    .coef_b0    (b0_r),
    .coef_a1    (a1_r),
    .coef_a2    (a2_r),
    .ctl        (ctl),
    .emit       (emit),
    .bypass     (bypass),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r.filtered, out_r.channel};
  assign out_tuser  = {out_r.guard_hit, out_r.clipped};

endmodule
